// ===== hw/rtl/bnn_pkg.sv =====
`default_nettype none
package bnn_pkg;

	localparam int ID_W     = 10;
	localparam int DIST_W   = 32;
	localparam int NODE_W   = 10;
	localparam int CFG_W    = 6;
	localparam int COUNT_W  = 6;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 8;
	localparam int LIMIT_W  = 7;

	localparam logic [CFG_W-1:0]  POOL_SIZE_RESET = 6'd20;
	localparam logic [DIST_W-1:0] SIGN_FLIP       = 32'h8000_0000;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic signed [DIST_W-1:0] distance;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic done;
		logic found;
	} worst_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bnn_ram.sv =====
`default_nettype none
module bnn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bnn_worst.sv =====
`default_nettype none
module bnn_worst #(
	parameter int MAX_POOL = 32,
	parameter int IW       = 5,
	parameter int CW       = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire bnn_pkg::entry_t [MAX_POOL-1:0]      row,
	input  wire logic [CW-1:0]                       count,
	output bnn_pkg::worst_status_t                   status,
	output logic [IW-1:0]                            worst_idx,
	output logic [bnn_pkg::DIST_W-1:0]               worst_key
);

	localparam int LEVELS = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 0;
	localparam int P2     = 1 << LEVELS;
	localparam int LVW    = $clog2(LEVELS + 2);

	logic [bnn_pkg::DIST_W-1:0] key_q [P2];
	logic [IW-1:0]              idx_q [P2];
	logic                       vld_q [P2];
	logic [LVW-1:0]             lvl_q;
	logic                       run_q;
	logic                       step;

	assign step = run_q && (lvl_q != LVW'(LEVELS));

	for (genvar j = 0; j < P2; j++) begin : g_slot
		logic [bnn_pkg::DIST_W-1:0] ld_key;
		logic                       ld_vld;
		logic [bnn_pkg::DIST_W-1:0] nx_key;
		logic [IW-1:0]              nx_idx;
		logic                       nx_vld;

		if (j < MAX_POOL) begin : g_ld
			assign ld_key = row[j].distance ^ bnn_pkg::SIGN_FLIP;
			assign ld_vld = (32'(count) > j);
		end else begin : g_pad
			assign ld_key = '0;
			assign ld_vld = 1'b0;
		end

		if (2 * j + 1 < P2) begin : g_pair
			logic pick_b;
			assign pick_b = vld_q[2*j+1] &&
				(!vld_q[2*j] || (key_q[2*j+1] > key_q[2*j]));
			assign nx_key = pick_b ? key_q[2*j+1] : key_q[2*j];
			assign nx_idx = pick_b ? idx_q[2*j+1] : idx_q[2*j];
			assign nx_vld = vld_q[2*j+1] || vld_q[2*j];
		end else begin : g_hold
			assign nx_key = key_q[j];
			assign nx_idx = idx_q[j];
			assign nx_vld = vld_q[j];
		end

		always_ff @(posedge clk) begin
			if (load) begin
				key_q[j] <= ld_key;
				idx_q[j] <= IW'(j);
				vld_q[j] <= ld_vld;
			end else if (step) begin
				key_q[j] <= nx_key;
				idx_q[j] <= nx_idx;
				vld_q[j] <= nx_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			lvl_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			lvl_q <= '0;
		end else if (step) begin
			lvl_q <= lvl_q + 1'b1;
		end
	end

	assign status.done  = run_q && (lvl_q == LVW'(LEVELS));
	assign status.found = vld_q[0];
	assign worst_idx    = idx_q[0];
	assign worst_key    = key_q[0];

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_nearest_neighbor_pool.sv =====
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  node, candidate, distance
// m_*       out        m_tvalid/m_tready  accepted, pool_count
// cfg_*     in         cfg_wr_en          pool_size
//
// Each in-range word passes through a row read, the worst-entry reduction tree at one
// level per cycle, a search state that sees the tree finish and a write-back; an idle
// state with s_tready high comes before the next word. Out-of-range words skip to the write-back.
// The result is presented on the cycle after the write-back.
// After reset a clearing pass zeroes the fill counts of all NODES nodes, during
// which no word is accepted. A stalled result holds the write-back until taken.
`default_nettype none
module bounded_nearest_neighbor_pool #(
	parameter int NODES    = 1024,
	parameter int MAX_POOL = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// node [9:0], candidate [19:10], distance [51:20]
	input  wire logic [bnn_pkg::S_DATA_W-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// accepted [0], pool_count [6:1]
	output logic [bnn_pkg::M_DATA_W-1:0]         m_tdata,
	input  wire logic                            cfg_wr_en,
	input  wire logic [bnn_pkg::CFG_W-1:0]       cfg_wr_data
);

	localparam int AW      = $clog2(NODES);
	localparam int IW      = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int CW      = $clog2(MAX_POOL + 1);
	localparam int ROW_W   = MAX_POOL * bnn_pkg::ENTRY_W;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;

	logic [2:0]                       state_q;
	logic [AW-1:0]                    clr_q;
	logic [bnn_pkg::CFG_W-1:0]        pool_size_q;
	logic [AW-1:0]                    addr_q;
	logic [bnn_pkg::ID_W-1:0]         cand_q;
	logic signed [bnn_pkg::DIST_W-1:0] dist_q;
	logic                             oor_q;
	logic                             present_q;
	logic                             out_valid_q;
	logic                             out_acc_q;
	logic [bnn_pkg::COUNT_W-1:0]      out_cnt_q;

	logic [bnn_pkg::NODE_W-1:0]       s_node;
	logic                             accept;
	logic                             in_range;
	logic                             decide_go;
	bnn_pkg::entry_t [MAX_POOL-1:0]   rd_row;
	bnn_pkg::entry_t [MAX_POOL-1:0]   new_row;
	logic [ROW_W-1:0]                 rd_row_raw;
	logic [CW-1:0]                    cnt_rd;
	logic [CW-1:0]                    new_cnt;
	logic                             row_wr_en;
	logic                             cnt_wr_en;
	logic [AW-1:0]                    cnt_wr_addr;
	logic [CW-1:0]                    cnt_wr_data;
	logic [bnn_pkg::LIMIT_W-1:0]      limit;
	logic                             present;
	logic                             do_append;
	logic                             do_replace;
	logic [bnn_pkg::DIST_W-1:0]       cand_key;
	bnn_pkg::worst_status_t           wst;
	logic [IW-1:0]                    worst_idx;
	logic [bnn_pkg::DIST_W-1:0]       worst_key;

	assign s_node   = s_tdata[9:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = (32'(s_node) < NODES);
	assign decide_go = (state_q == ST_DECIDE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= bnn_pkg::POOL_SIZE_RESET;
		end else if (cfg_wr_en) begin
			pool_size_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (pool_size_q == '0) begin
			limit = bnn_pkg::LIMIT_W'(1);
		end else if (bnn_pkg::LIMIT_W'(pool_size_q) > bnn_pkg::LIMIT_W'(MAX_POOL)) begin
			limit = bnn_pkg::LIMIT_W'(MAX_POOL);
		end else begin
			limit = bnn_pkg::LIMIT_W'(pool_size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_range ? ST_READ : ST_DECIDE;
					end
				end
				ST_READ: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (wst.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (decide_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= AW'(s_node);
			cand_q <= s_tdata[19:10];
			dist_q <= s_tdata[51:20];
			oor_q  <= !in_range;
		end
		if (state_q == ST_READ) begin
			present_q <= present;
		end
	end

	bnn_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NODES),
		.AW    (AW)
	) u_row_mem (
		.clk     (clk),
		.wr_en   (row_wr_en),
		.wr_addr (addr_q),
		.wr_data (ROW_W'(new_row)),
		.rd_en   (accept && in_range),
		.rd_addr (AW'(s_node)),
		.rd_data (rd_row_raw)
	);

	assign rd_row = rd_row_raw;

	bnn_ram #(
		.WIDTH (CW),
		.DEPTH (NODES),
		.AW    (AW)
	) u_cnt_mem (
		.clk     (clk),
		.wr_en   (cnt_wr_en),
		.wr_addr (cnt_wr_addr),
		.wr_data (cnt_wr_data),
		.rd_en   (accept && in_range),
		.rd_addr (AW'(s_node)),
		.rd_data (cnt_rd)
	);

	bnn_worst #(
		.MAX_POOL (MAX_POOL),
		.IW       (IW),
		.CW       (CW)
	) u_worst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (state_q == ST_READ),
		.row       (rd_row),
		.count     (cnt_rd),
		.status    (wst),
		.worst_idx (worst_idx),
		.worst_key (worst_key)
	);

	always_comb begin
		present = 1'b0;
		for (int k = 0; k < MAX_POOL; k++) begin
			if ((rd_row[k].id == cand_q) && (32'(cnt_rd) > k)) begin
				present = 1'b1;
			end
		end
	end

	assign cand_key   = dist_q ^ bnn_pkg::SIGN_FLIP;
	assign do_append  = !oor_q && !present_q &&
		(bnn_pkg::LIMIT_W'(cnt_rd) < limit);
	assign do_replace = !oor_q && !present_q && !do_append && wst.found &&
		(cand_key < worst_key);

	always_comb begin
		new_row = rd_row;
		new_cnt = cnt_rd;
		if (do_append) begin
			new_row[cnt_rd[IW-1:0]] = '{id: cand_q, distance: dist_q};
			new_cnt = cnt_rd + 1'b1;
		end else if (do_replace) begin
			new_row[worst_idx] = '{id: cand_q, distance: dist_q};
		end
	end

	assign row_wr_en   = decide_go && (do_append || do_replace);
	assign cnt_wr_en   = (state_q == ST_CLEAR) || (decide_go && do_append);
	assign cnt_wr_addr = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign cnt_wr_data = (state_q == ST_CLEAR) ? '0 : new_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (decide_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (decide_go) begin
			out_acc_q <= do_append || do_replace;
			out_cnt_q <= oor_q ? '0 : bnn_pkg::COUNT_W'(new_cnt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_acc_q};

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		decide_go |=> (m_tvalid && (state_q == ST_IDLE)))
		else $error("write-back did not present a result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_wr_en |-> (32'(cnt_wr_data) <= MAX_POOL))
		else $error("fill count above pool capacity");

	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && !oor_q) |-> wst.done)
		else $error("write-back before worst-entry search finished");
`endif

endmodule
`default_nettype wire

// ===== tb/bounded_nearest_neighbor_pool_tb.sv =====
`timescale 1ns / 1ps
module bounded_nearest_neighbor_pool_tb;

	localparam int NODE_COUNT = 1024;
	localparam int POOL_MAX   = 32;
	localparam int PAD_W      = bnn_pkg::S_DATA_W - bnn_pkg::NODE_W - bnn_pkg::ID_W -
		bnn_pkg::DIST_W;

	typedef struct packed {
		logic                        accepted;
		logic [bnn_pkg::COUNT_W-1:0] count;
	} pool_result_t;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         s_tvalid    = 1'b0;
	logic                         s_tready;
	logic [bnn_pkg::S_DATA_W-1:0] s_tdata     = '0;
	logic                         m_tvalid;
	logic                         m_tready    = 1'b0;
	logic [bnn_pkg::M_DATA_W-1:0] m_tdata;
	logic                         cfg_wr_en   = 1'b0;
	logic [bnn_pkg::CFG_W-1:0]    cfg_wr_data = '0;

	logic [bnn_pkg::ID_W-1:0]          pool_ids   [0:NODE_COUNT-1][0:POOL_MAX-1];
	logic signed [bnn_pkg::DIST_W-1:0] pool_dists [0:NODE_COUNT-1][0:POOL_MAX-1];
	int                                pool_fill  [0:NODE_COUNT-1];
	logic [bnn_pkg::CFG_W-1:0]         pool_size_reg = bnn_pkg::POOL_SIZE_RESET;

	pool_result_t pending_results [$];
	int           error_count     = 0;
	int           rx_stall_cycles = 0;
	int           rx_gap_left     = 0;
	bit           no_idle         = 1'b0;

	bounded_nearest_neighbor_pool #(
		.NODES(NODE_COUNT),
		.MAX_POOL(POOL_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	function automatic pool_result_t predict_pool_update(
			input logic [bnn_pkg::NODE_W-1:0] node, input logic [bnn_pkg::ID_W-1:0] cand,
			input logic signed [bnn_pkg::DIST_W-1:0] offer_dist);
		int           limit;
		int           count;
		int           worst;
		bit           present;
		pool_result_t res;
		limit = int'(pool_size_reg);
		if (limit < 1) limit = 1;
		if (limit > POOL_MAX) limit = POOL_MAX;
		count = pool_fill[node];
		present = 1'b0;
		res.accepted = 1'b0;
		for (int k = 0; k < count; k++)
			if (pool_ids[node][k] == cand) present = 1'b1;
		if (!present) begin
			if (count < limit) begin
				pool_ids[node][count] = cand;
				pool_dists[node][count] = offer_dist;
				count++;
				pool_fill[node] = count;
				res.accepted = 1'b1;
			end else if (count > 0) begin
				worst = 0;
				for (int k = 1; k < count; k++)
					if (pool_dists[node][k] > pool_dists[node][worst]) worst = k;
				if (offer_dist < pool_dists[node][worst]) begin
					pool_ids[node][worst] = cand;
					pool_dists[node][worst] = offer_dist;
					res.accepted = 1'b1;
				end
			end
		end
		res.count = count[bnn_pkg::COUNT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch in %s, got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", int'(m_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.accepted)
					report_mismatch("accepted", int'(m_tdata[0]), int'(want.accepted));
				if (m_tdata[bnn_pkg::COUNT_W:1] !== want.count)
					report_mismatch("pool_count", int'(m_tdata[bnn_pkg::COUNT_W:1]),
						int'(want.count));
			end
			rx_gap_left = no_idle ? 0 : int'($urandom_range(0, 7));
		end
		if (rx_stall_cycles > 0) begin
			m_tready <= 1'b0;
			rx_stall_cycles = rx_stall_cycles - 1;
		end else if (rx_gap_left > 0) begin
			m_tready <= 1'b0;
			rx_gap_left = rx_gap_left - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_offer(input logic [bnn_pkg::NODE_W-1:0] node,
			input logic [bnn_pkg::ID_W-1:0] cand, input logic [bnn_pkg::DIST_W-1:0] offer_dist);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 7));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{PAD_W{1'b0}}, offer_dist, cand, node};
		do @(posedge clk); while (!s_tready);
		pending_results.insert(pending_results.size(),
			predict_pool_update(node, cand, offer_dist));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_pool_size(input logic [bnn_pkg::CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pool_size_reg = value;
	endtask

	task automatic test_directed_cases();
		// Reset pool size: appends at the extremes and a duplicate in a pool that is not full.
		send_offer(10'd0, 10'd0, 32'h7FFF_FFFF);
		send_offer(10'd0, 10'd0, 32'hFFFF_FFFB);
		send_offer(10'd1023, 10'd1023, 32'h8000_0000);
		send_offer(10'd1023, 10'd1, 32'h0000_0000);
		wait_results_drained();
		// A pool of one: equal distance, closer, duplicate, most negative, and a pool
		// that already holds more entries than the new size.
		set_pool_size(6'd1);
		send_offer(10'd0, 10'd5, 32'h7FFF_FFFF);
		send_offer(10'd0, 10'd5, 32'd100);
		send_offer(10'd0, 10'd5, -32'sd100);
		send_offer(10'd0, 10'd6, 32'h8000_0000);
		send_offer(10'd1023, 10'd7, 32'hFFFF_FFFF);
		wait_results_drained();
		// A size of zero behaves as one.
		set_pool_size(6'd0);
		send_offer(10'd3, 10'd9, 32'd10);
		send_offer(10'd3, 10'd10, 32'd10);
		send_offer(10'd3, 10'd10, 32'd9);
		wait_results_drained();
		// Ties on the worst distance go to the lowest slot.
		set_pool_size(6'd3);
		send_offer(10'd4, 10'd1, 32'd50);
		send_offer(10'd4, 10'd2, 32'd50);
		send_offer(10'd4, 10'd3, 32'd20);
		send_offer(10'd4, 10'd4, 32'd40);
		send_offer(10'd4, 10'd5, 32'd45);
		wait_results_drained();
		// A size above the maximum is clamped.
		set_pool_size(6'd63);
		send_offer(10'd4, 10'd6, 32'd0);
		send_offer(10'd4, 10'd4, 32'd1);
	endtask

	task automatic test_output_backpressure();
		wait_results_drained();
		set_pool_size(6'd4);
		no_idle = 1'b1;
		rx_stall_cycles = 150;
		repeat (24) send_offer(bnn_pkg::NODE_W'($urandom_range(100, 102)),
			bnn_pkg::ID_W'($urandom_range(0, 15)), $urandom_range(0, 999));
		no_idle = 1'b0;
		wait_results_drained();
	endtask

	task automatic test_random_phase(input logic [bnn_pkg::CFG_W-1:0] psize,
			input int n_items, input int n_hot, input bit burst);
		logic [bnn_pkg::NODE_W-1:0] hot [0:3];
		logic [bnn_pkg::NODE_W-1:0] node;
		logic [bnn_pkg::ID_W-1:0]   cand;
		logic [bnn_pkg::DIST_W-1:0] offer_dist;
		wait_results_drained();
		set_pool_size(psize);
		no_idle = burst;
		for (int i = 0; i < 4; i++)
			hot[i] = bnn_pkg::NODE_W'($urandom_range(0, NODE_COUNT - 1));
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) == 0) node = bnn_pkg::NODE_W'($urandom);
			else node = hot[$urandom_range(0, n_hot - 1)];
			if ($urandom_range(0, 2) == 0) cand = bnn_pkg::ID_W'($urandom);
			else cand = bnn_pkg::ID_W'($urandom_range(0, 47));
			case ($urandom_range(0, 3))
				0: offer_dist = $urandom;
				1: offer_dist = $urandom_range(0, 4095) - 2048;
				2: offer_dist = {16'($urandom_range(0, 255) - 128), 16'($urandom)};
				default: begin
					case ($urandom_range(0, 2))
						0: offer_dist = 32'h7FFF_FFFF;
						1: offer_dist = 32'h8000_0000;
						default: offer_dist = 32'h0000_0000;
					endcase
				end
			endcase
			send_offer(node, cand, offer_dist);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_output_backpressure();
		test_random_phase(6'd1, 60, 3, 1'b0);
		test_random_phase(6'd32, 100, 2, 1'b0);
		test_random_phase(6'd63, 50, 2, 1'b0);
		test_random_phase(6'd0, 40, 3, 1'b0);
		test_random_phase(bnn_pkg::CFG_W'($urandom_range(1, 32)), 60, 4, 1'b0);
		test_random_phase(6'd8, 60, 3, 1'b1);
		test_random_phase(bnn_pkg::POOL_SIZE_RESET, 40, 4, 1'b0);
		wait_results_drained();
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
